### rtl/longest_common_substring_length_macros.svh
// Assertion helpers for the longest common substring length block.
// Both sample on aclk and are held off while aresetn is low.
`ifndef LONGEST_COMMON_SUBSTRING_LENGTH_MACROS_SVH
`define LONGEST_COMMON_SUBSTRING_LENGTH_MACROS_SVH

// Property that must hold in every cycle.
`define LCSL_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lcsl_pkg.sv
package lcsl_pkg;

    // Default capacity of the first-string store
    localparam int unsigned MAX_LEN_DEF = 1024;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned LENGTH_W  = 11;
    localparam int unsigned M_TDATA_W = 16;

    // Meaning of the input tuser bit
    localparam logic MODE_FIRST  = 1'b0;
    localparam logic MODE_SECOND = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // store a first-string byte
        logic start;  // latch a second-string byte and arm the row walk
        logic issue;  // walk one row entry (datapath stops at index zero)
        logic emit;   // load the result register and clear the runs
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic walk_done;  // row walk finished and pipeline drained
        logic walk_last;  // byte under walk closed the second string
        logic out_free;   // result register can take a new value
    } stat_t;

endpackage

### rtl/lcsl_ctrl.sv
module lcsl_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_mode,
    input  lcsl_pkg::stat_t stat,
    output logic            s_ready,
    output lcsl_pkg::cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       take;

    assign s_ready = (state_reg == ST_IDLE);
    assign take    = s_ready && s_valid;

    // Command decode
    always_comb begin
        cmd       = '0;
        cmd.load  = take && (s_mode == lcsl_pkg::MODE_FIRST);
        cmd.start = take && (s_mode == lcsl_pkg::MODE_SECOND);
        cmd.issue = (state_reg == ST_WALK);
        cmd.emit  = (state_reg == ST_FIN) && stat.out_free;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (stat.walk_done) begin
                    state_next = stat.walk_last ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/lcsl_dp.sv
module lcsl_dp #(
    parameter int unsigned MAX_LEN = lcsl_pkg::MAX_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lcsl_pkg::CH_W-1:0]     in_ch,
    input  logic                          in_last,
    input  lcsl_pkg::cmd_t                cmd,
    input  logic                          out_ready,
    output lcsl_pkg::stat_t               stat,
    output logic                          out_valid,
    output logic [lcsl_pkg::LENGTH_W-1:0] out_length,
    output logic                          out_too_long
);

    localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned CW = $clog2(MAX_LEN + 1);

    // Memories
    logic [lcsl_pkg::CH_W-1:0] store_mem [MAX_LEN];
    logic [CW-1:0]             run_mem   [MAX_LEN];
    logic [lcsl_pkg::CH_W-1:0] store_rd_reg;
    logic [CW-1:0]             run_rd_reg;

    // Pair and walk state
    logic [CW-1:0]             first_len_reg;
    logic                      overflow_reg;
    logic                      closed_reg;
    logic                      rows_clear_reg;
    logic                      walk_zero_reg;
    logic [CW-1:0]             best_reg;
    logic [lcsl_pkg::CH_W-1:0] ch_reg;
    logic                      last_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      p_valid_reg;
    logic [AW-1:0]             p_idx_reg;
    logic                      p_first_reg;

    // Result register
    logic                          out_valid_reg;
    logic [lcsl_pkg::LENGTH_W-1:0] out_len_reg;
    logic                          out_long_reg;

    logic [CW-1:0] load_base;
    logic          load_fits;
    logic [CW-1:0] first_len_next;
    logic          issue_go;
    logic [CW-1:0] rd_idx;
    logic [CW-1:0] diag_idx;
    logic          match;
    logic [CW-1:0] diag;
    logic [CW-1:0] run_v;

    // Load position: a byte after a closed string restarts at zero
    assign load_base      = closed_reg ? '0 : first_len_reg;
    assign load_fits      = (load_base < CW'(MAX_LEN));
    assign first_len_next = load_fits ? load_base + CW'(1) : load_base;

    // Walk addresses: entry i and its diagonal i-1
    assign issue_go = cmd.issue && (cnt_reg != '0);
    assign rd_idx   = cnt_reg - CW'(1);
    assign diag_idx = cnt_reg - CW'(2);

    // Compute stage
    assign match = (store_rd_reg == ch_reg);
    assign diag  = (p_first_reg || walk_zero_reg) ? '0 : run_rd_reg;
    assign run_v = match ? diag + CW'(1) : '0;

    // First-string store
    always_ff @(posedge aclk) begin
        if (cmd.load && load_fits) begin
            store_mem[load_base[AW-1:0]] <= in_ch;
        end
        store_rd_reg <= store_mem[rd_idx[AW-1:0]];
    end

    // Run-length row
    always_ff @(posedge aclk) begin
        if (p_valid_reg) begin
            run_mem[p_idx_reg] <= run_v;
        end
        run_rd_reg <= run_mem[diag_idx[AW-1:0]];
    end

    // Pair bookkeeping, walk counter and running maximum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_len_reg  <= '0;
            overflow_reg   <= 1'b0;
            closed_reg     <= 1'b1;
            rows_clear_reg <= 1'b1;
            walk_zero_reg  <= 1'b1;
            best_reg       <= '0;
            last_reg       <= 1'b0;
            cnt_reg        <= '0;
            p_valid_reg    <= 1'b0;
        end else begin
            p_valid_reg <= issue_go;
            if (cmd.load) begin
                first_len_reg <= first_len_next;
                overflow_reg  <= !load_fits || (overflow_reg && !closed_reg);
                closed_reg    <= in_last;
                if (closed_reg) begin
                    best_reg       <= '0;
                    rows_clear_reg <= 1'b1;
                end
            end
            if (cmd.start) begin
                closed_reg     <= 1'b1;
                last_reg       <= in_last;
                cnt_reg        <= first_len_reg;
                walk_zero_reg  <= rows_clear_reg;
                rows_clear_reg <= 1'b0;
            end
            if (issue_go) begin
                cnt_reg <= rd_idx;
            end
            if (p_valid_reg && (run_v > best_reg)) begin
                best_reg <= run_v;
            end
            if (cmd.emit) begin
                best_reg       <= '0;
                rows_clear_reg <= 1'b1;
            end
        end
    end

    // Payload of the walk pipeline
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            ch_reg <= in_ch;
        end
        p_idx_reg   <= rd_idx[AW-1:0];
        p_first_reg <= (rd_idx == '0);
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_len_reg  <= lcsl_pkg::LENGTH_W'(best_reg);
            out_long_reg <= overflow_reg;
        end
    end

    assign stat.walk_done = (cnt_reg == '0) && !p_valid_reg;
    assign stat.walk_last = last_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_length   = out_len_reg;
    assign out_too_long = out_long_reg;

endmodule

### rtl/longest_common_substring_length.sv
// Channel   Dir  Ports                        Transaction
// s_        in   tvalid tready tdata tuser    one string byte (tuser = second string,
//                       tlast                  tlast = final byte of the string)
// m_        out  tvalid tready tdata          one result after the last second-string byte
//
// A first-string byte is stored as it is taken. A second-string byte starts a walk
// over the stored first string: the walk reads one store entry and one run
// entry per cycle, then the compute stage drains and the controller sees the walk end.
// A closing byte also has the result register loaded. Reset (aresetn,
// synchronous, active low) needs no clearing pass. A stalled m_ channel only
// holds the block when a new result is ready and the previous one is not taken.
`include "longest_common_substring_length_macros.svh"

module longest_common_substring_length #(
    parameter int unsigned MAX_LEN = lcsl_pkg::MAX_LEN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lcsl_pkg::CH_W-1:0]      s_tdata,   // [7:0] ch
    input  logic                           s_tuser,   // [0] mode
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lcsl_pkg::M_TDATA_W-1:0] m_tdata    // [10:0] length, [11] too_long
);

    lcsl_pkg::cmd_t                cmd;
    lcsl_pkg::stat_t               stat;
    logic [lcsl_pkg::LENGTH_W-1:0] res_length;
    logic                          res_too_long;

    lcsl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_mode  (s_tuser),
        .stat    (stat),
        .s_ready (s_tready),
        .cmd     (cmd)
    );

    lcsl_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_ch        (s_tdata),
        .in_last      (s_tlast),
        .cmd          (cmd),
        .out_ready    (m_tready),
        .stat         (stat),
        .out_valid    (m_tvalid),
        .out_length   (res_length),
        .out_too_long (res_too_long)
    );

    assign m_tdata = {
        (lcsl_pkg::M_TDATA_W - lcsl_pkg::LENGTH_W - 1)'(0), res_too_long, res_length
    };

    // A second-string byte always leaves the block busy in the cycle after it is taken
    `LCSL_ASSERT_NEXT(a_walk_blocks, s_tvalid && s_tready && s_tuser, !s_tready, "walk not busy")
    // A result is never loaded over one that is still waiting
    `LCSL_ASSERT_ALWAYS(a_emit_free, !cmd.emit || !m_tvalid || m_tready, "result overwritten")
    // A loaded result is offered on the next cycle
    `LCSL_ASSERT_NEXT(a_emit_shows, cmd.emit, m_tvalid, "result not shown")

endmodule
